// ===== rtl/rlzgd_pkg.sv =====
`default_nettype none

package rlzgd_pkg;

	// history and chunk geometry
	localparam int HIST_DEPTH  = 4096;
	localparam int HIST_AW     = $clog2(HIST_DEPTH);
	localparam int CNT_W       = HIST_AW + 1;
	localparam int CHUNK_BYTES = 16;
	localparam int CHUNK_IW    = $clog2(CHUNK_BYTES);
	localparam int CHUNK_CW    = CHUNK_IW + 1;
	localparam int DEC_W       = 13;

	// run length counter, copy source address and a compare width covering the run length and the write count
	localparam int RUN_W = 11;
	localparam int SRC_W = 17;
	localparam int CMP_W = (CNT_W > RUN_W) ? CNT_W : RUN_W;

	// header byte codes
	localparam logic [7:0] END_CODE = 8'hFF;
	localparam logic [2:0] EXT_MARK = 3'b111;

	// command modes
	localparam logic [2:0] MODE_LITERAL = 3'd0;
	localparam logic [2:0] MODE_BYTE    = 3'd1;
	localparam logic [2:0] MODE_WORD    = 3'd2;
	localparam logic [2:0] MODE_INC     = 3'd3;

	// parser phases
	localparam logic [2:0] PH_HEADER      = 3'd0;
	localparam logic [2:0] PH_EXTCOUNT    = 3'd1;
	localparam logic [2:0] PH_LITERAL     = 3'd2;
	localparam logic [2:0] PH_SINGLE      = 3'd3;
	localparam logic [2:0] PH_PAIR_FIRST  = 3'd4;
	localparam logic [2:0] PH_PAIR_SECOND = 3'd5;

	// byte generator kinds
	localparam logic [1:0] KIND_FILL = 2'd0;
	localparam logic [1:0] KIND_INC  = 2'd1;
	localparam logic [1:0] KIND_ALT  = 2'd2;
	localparam logic [1:0] KIND_COPY = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [63:0]      chunk_low;
		logic [63:0]      chunk_high;
		logic [4:0]       byte_count;
		logic             last_chunk;
		logic             stream_done;
		logic             overflow;
		logic [DEC_W-1:0] decoded_length;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rle_lz_graphics_decompressor_unit.sv =====
`default_nettype none

// LC_LZ2 style graphics decompressor. Compressed bytes come in one per input
// transaction; decoded bytes go out in chunks of up to 16, the last chunk of an
// input flagged with last_chunk. Header, count and operand bytes that start no
// output are taken one per cycle while the block is idle. A literal byte is
// accepted, then written, then its chunk is handed out. After its last operand
// is accepted, a run (byte, word or incrementing) keeps the input stalled while
// its bytes are written and its chunks handed out; a copy does the same, and
// every copied byte needs a read and then a write on the single port of the
// 4096-byte history RAM. Any stall on the output lengthens the input stall. The
// block takes no input while a command is still expanding. Copy reads at or
// past the current write count return zero; bytes beyond the history are
// dropped and reported through overflow. cfg_wr_data selects the copy offset
// byte order (0 first byte low, 1 first byte high) and may only be written
// while the block is idle.
module rle_lz_graphics_decompressor_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic                 cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire rlzgd_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output rlzgd_pkg::out_item_t      out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_GEN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic       big_endian_q;

	// stream parser state
	logic [rlzgd_pkg::CNT_W-1:0] wc_q;
	logic [2:0]                  phase_q;
	logic [2:0]                  mode_q;
	logic [rlzgd_pkg::RUN_W-1:0] rem_q;
	logic [7:0]                  held_q;
	logic                        done_q;

	// byte generator
	logic [rlzgd_pkg::RUN_W-1:0] gen_left_q;
	logic [1:0]                  kind_q;
	logic [7:0]                  val_q;
	logic [7:0]                  alt_q;
	logic [rlzgd_pkg::SRC_W-1:0] src_q;
	logic                        rd_ok_q;
	logic                        drop_q;
	logic                        fin_done_q;
	logic                        last_q;

	// chunk assembly and output register
	logic [rlzgd_pkg::CHUNK_BYTES-1:0][7:0] asm_data_q;
	logic [rlzgd_pkg::CHUNK_CW-1:0]         asm_cnt_q;
	rlzgd_pkg::out_item_t                   out_q;
	logic                                   out_valid_q;

	// ram port
	logic                          ram_we;
	logic [rlzgd_pkg::HIST_AW-1:0] ram_addr;
	logic [7:0]                    ram_rdata;

	// effective state after an optional stream restart
	logic [7:0]                  b;
	logic [rlzgd_pkg::CNT_W-1:0] eff_wc;
	logic [2:0]                  eff_phase;
	logic [2:0]                  eff_mode;
	logic [rlzgd_pkg::RUN_W-1:0] eff_rem;
	logic [7:0]                  eff_held;
	logic                        eff_done;
	logic [rlzgd_pkg::CNT_W-1:0] space;
	logic [rlzgd_pkg::CMP_W-1:0] rem_ext;
	logic [rlzgd_pkg::CMP_W-1:0] space_ext;
	logic                        rem_fits;

	// decoder results
	logic [2:0]                  nxt_phase;
	logic [2:0]                  nxt_mode;
	logic [rlzgd_pkg::RUN_W-1:0] nxt_rem;
	logic [7:0]                  nxt_held;
	logic                        nxt_done;
	logic [rlzgd_pkg::RUN_W-1:0] gen_n;
	logic [1:0]                  gen_kind;
	logic [7:0]                  gen_val;
	logic [7:0]                  gen_alt;
	logic [15:0]                 gen_src;
	logic                        drop;

	logic       accept;
	logic       out_free;
	logic       gen_last;
	logic       chunk_full;
	logic [7:0] byte_v;

	function automatic logic [2:0] data_phase(input logic [2:0] mode);
		logic [2:0] ph;
		if (mode == rlzgd_pkg::MODE_LITERAL) begin
			ph = rlzgd_pkg::PH_LITERAL;
		end else if (mode == rlzgd_pkg::MODE_BYTE || mode == rlzgd_pkg::MODE_INC) begin
			ph = rlzgd_pkg::PH_SINGLE;
		end else begin
			ph = rlzgd_pkg::PH_PAIR_FIRST;
		end
		return ph;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// restart view of the parser
	assign b         = in_data.in_byte;
	assign eff_wc    = in_data.stream_start ? '0 : wc_q;
	assign eff_phase = in_data.stream_start ? rlzgd_pkg::PH_HEADER : phase_q;
	assign eff_mode  = in_data.stream_start ? rlzgd_pkg::MODE_LITERAL : mode_q;
	assign eff_rem   = in_data.stream_start ? '0 : rem_q;
	assign eff_held  = in_data.stream_start ? 8'h00 : held_q;
	assign eff_done  = in_data.stream_start ? 1'b0 : done_q;
	assign space     = rlzgd_pkg::CNT_W'(rlzgd_pkg::HIST_DEPTH) - eff_wc;
	assign rem_ext   = rlzgd_pkg::CMP_W'(eff_rem);
	assign space_ext = rlzgd_pkg::CMP_W'(space);
	assign rem_fits  = (rem_ext <= space_ext);

	// command decode for one input byte
	always_comb begin
		nxt_phase = eff_phase;
		nxt_mode  = eff_mode;
		nxt_rem   = eff_rem;
		nxt_held  = eff_held;
		nxt_done  = eff_done;
		gen_n     = '0;
		gen_kind  = rlzgd_pkg::KIND_FILL;
		gen_val   = b;
		gen_alt   = b;
		gen_src   = 16'h0000;
		drop      = 1'b0;
		unique case (eff_phase)
			rlzgd_pkg::PH_HEADER: begin
				if (b == rlzgd_pkg::END_CODE) begin
					nxt_done = 1'b1;
				end else if (b[7:5] == rlzgd_pkg::EXT_MARK) begin
					nxt_mode  = b[4:2];
					nxt_rem   = {1'b0, b[1:0], 8'h00};
					nxt_phase = rlzgd_pkg::PH_EXTCOUNT;
				end else begin
					nxt_mode  = b[7:5];
					nxt_rem   = rlzgd_pkg::RUN_W'(b[4:0]) + rlzgd_pkg::RUN_W'(1);
					nxt_phase = data_phase(b[7:5]);
				end
			end
			rlzgd_pkg::PH_EXTCOUNT: begin
				nxt_rem   = {1'b0, eff_rem[9:8], b} + rlzgd_pkg::RUN_W'(1);
				nxt_phase = data_phase(eff_mode);
			end
			rlzgd_pkg::PH_LITERAL: begin
				gen_n   = (space != '0) ? rlzgd_pkg::RUN_W'(1) : '0;
				drop    = (space == '0);
				nxt_rem = eff_rem - rlzgd_pkg::RUN_W'(1);
				if (eff_rem <= rlzgd_pkg::RUN_W'(1)) begin
					nxt_rem   = '0;
					nxt_phase = rlzgd_pkg::PH_HEADER;
					nxt_done  = (space <= rlzgd_pkg::CNT_W'(1));
				end
			end
			rlzgd_pkg::PH_SINGLE: begin
				gen_n     = rem_fits ? eff_rem : rlzgd_pkg::RUN_W'(space);
				drop      = !rem_fits;
				gen_kind  = (eff_mode == rlzgd_pkg::MODE_INC) ? rlzgd_pkg::KIND_INC
					: rlzgd_pkg::KIND_FILL;
				nxt_rem   = '0;
				nxt_phase = rlzgd_pkg::PH_HEADER;
				nxt_done  = (rem_ext >= space_ext);
			end
			rlzgd_pkg::PH_PAIR_FIRST: begin
				nxt_held  = b;
				nxt_phase = rlzgd_pkg::PH_PAIR_SECOND;
			end
			default: begin
				gen_n     = rem_fits ? eff_rem : rlzgd_pkg::RUN_W'(space);
				drop      = !rem_fits;
				gen_kind  = (eff_mode == rlzgd_pkg::MODE_WORD) ? rlzgd_pkg::KIND_ALT
					: rlzgd_pkg::KIND_COPY;
				gen_val   = eff_held;
				gen_alt   = b;
				gen_src   = big_endian_q ? {eff_held, b} : {b, eff_held};
				nxt_rem   = '0;
				nxt_phase = rlzgd_pkg::PH_HEADER;
				nxt_done  = (rem_ext >= space_ext);
			end
		endcase
	end

	// next byte of the run
	always_comb begin
		unique case (kind_q)
			rlzgd_pkg::KIND_COPY: byte_v = rd_ok_q ? ram_rdata : 8'h00;
			default:              byte_v = val_q;
		endcase
	end

	assign gen_last   = (gen_left_q == rlzgd_pkg::RUN_W'(1));
	assign chunk_full = (asm_cnt_q == rlzgd_pkg::CHUNK_CW'(rlzgd_pkg::CHUNK_BYTES - 1));

	// history ram: read for copies, write for every produced byte
	assign ram_we   = (state_q == ST_GEN);
	assign ram_addr = (state_q == ST_READ) ? src_q[rlzgd_pkg::HIST_AW-1:0]
		: wc_q[rlzgd_pkg::HIST_AW-1:0];

	rlzgd_ram #(
		.WIDTH(8),
		.DEPTH(rlzgd_pkg::HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(byte_v),
		.rdata(ram_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_wr_en) begin
			big_endian_q <= cfg_wr_data;
		end
	end

	// sequencer and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wc_q        <= '0;
			phase_q     <= rlzgd_pkg::PH_HEADER;
			mode_q      <= rlzgd_pkg::MODE_LITERAL;
			rem_q       <= '0;
			held_q      <= 8'h00;
			done_q      <= 1'b0;
			asm_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !eff_done) begin
						wc_q      <= eff_wc;
						phase_q   <= nxt_phase;
						mode_q    <= nxt_mode;
						rem_q     <= nxt_rem;
						held_q    <= nxt_held;
						done_q    <= nxt_done;
						asm_cnt_q <= '0;
						if (gen_n != '0) begin
							state_q <= (gen_kind == rlzgd_pkg::KIND_COPY) ? ST_READ : ST_GEN;
						end else if (drop || nxt_done) begin
							state_q <= ST_EMIT;
						end
					end else if (accept) begin
						wc_q <= eff_wc;
					end
				end
				ST_READ: begin
					state_q <= ST_GEN;
				end
				ST_GEN: begin
					wc_q      <= wc_q + rlzgd_pkg::CNT_W'(1);
					asm_cnt_q <= asm_cnt_q + rlzgd_pkg::CHUNK_CW'(1);
					if (gen_last || chunk_full) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= (kind_q == rlzgd_pkg::KIND_COPY) ? ST_READ : ST_GEN;
					end
				end
				default: begin
					if (out_free) begin
						asm_cnt_q <= '0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= (kind_q == rlzgd_pkg::KIND_COPY) ? ST_READ : ST_GEN;
						end
					end
				end
			endcase
		end
	end

	// generator datapath and chunk assembly
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				asm_data_q <= '0;
				last_q     <= 1'b1;
				gen_left_q <= gen_n;
				kind_q     <= gen_kind;
				val_q      <= gen_val;
				alt_q      <= gen_alt;
				src_q      <= rlzgd_pkg::SRC_W'(gen_src);
				drop_q     <= drop;
				fin_done_q <= nxt_done;
			end
			ST_READ: begin
				rd_ok_q <= (src_q < rlzgd_pkg::SRC_W'(wc_q));
			end
			ST_GEN: begin
				asm_data_q[asm_cnt_q[rlzgd_pkg::CHUNK_IW-1:0]] <= byte_v;
				gen_left_q <= gen_left_q - rlzgd_pkg::RUN_W'(1);
				last_q     <= gen_last;
				unique case (kind_q)
					rlzgd_pkg::KIND_INC: val_q <= val_q + 8'd1;
					rlzgd_pkg::KIND_ALT: begin
						val_q <= alt_q;
						alt_q <= val_q;
					end
					rlzgd_pkg::KIND_COPY: src_q <= src_q + rlzgd_pkg::SRC_W'(1);
					default: val_q <= val_q;
				endcase
			end
			default: begin
				if (out_free) begin
					out_q.chunk_low      <= asm_data_q[7:0];
					out_q.chunk_high     <= asm_data_q[15:8];
					out_q.byte_count     <= 5'(asm_cnt_q);
					out_q.last_chunk     <= last_q;
					out_q.stream_done    <= fin_done_q;
					out_q.overflow       <= drop_q;
					out_q.decoded_length <= rlzgd_pkg::DEC_W'(wc_q);
					asm_data_q           <= '0;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rlzgd_ram.sv =====
`default_nettype none

module rlzgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/rlzgd_checker.sv =====
`default_nettype none

module rlzgd_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire rlzgd_pkg::out_item_t out_data
);

	// a held result transaction keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// chunk never carries more than its capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_count <= 5'(rlzgd_pkg::CHUNK_BYTES))
		else $error("chunk byte count too large");

	// an empty chunk only reports an end or a drop, and is the last one
	a_empty_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_count == 5'd0
		|-> out_data.last_chunk && (out_data.stream_done || out_data.overflow))
		else $error("empty chunk without cause");

	// only the final chunk of an input may be partly filled
	a_full_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_chunk
		|-> out_data.byte_count == 5'(rlzgd_pkg::CHUNK_BYTES))
		else $error("partial chunk before the last one");

endmodule

bind rle_lz_graphics_decompressor_unit rlzgd_checker u_rlzgd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
	import rlzgd_pkg::*;

	// copy commands occupy the upper half of the mode space
	localparam logic [2:0] MODE_COPY_FIRST = 3'd4;
	localparam logic [2:0] MODE_COPY_TOP   = 3'd7;
	localparam int         MAX_RUN_LEN     = 1024;
	localparam int         LIMIT_CYCLES    = 4_000_000;

	// model of the decoder: history, parser and the queue of chunks still owed
	class chunk_scoreboard;
		logic [7:0]  hist [HIST_DEPTH];
		int unsigned wr_count;
		logic [2:0]  phase;
		logic [2:0]  mode;
		int unsigned remaining;
		logic [7:0]  held;
		bit          done;
		bit          big_endian;
		bit          dropped;
		logic [7:0]  step_bytes [$];
		out_item_t   chunks_due [$];
		int unsigned errors;
		int unsigned n_bytes_in;
		int unsigned n_chunks;

		function new();
			big_endian = 1'b0;
			errors     = 0;
			n_bytes_in = 0;
			n_chunks   = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			wr_count  = 0;
			phase     = PH_HEADER;
			mode      = MODE_LITERAL;
			remaining = 0;
			held      = 8'h00;
			done      = 1'b0;
		endfunction

		function int unsigned pending();
			return chunks_due.size();
		endfunction

		// bytes past the history are dropped and flagged
		function void put(logic [7:0] v);
			if (wr_count < HIST_DEPTH) begin
				hist[wr_count] = v;
				wr_count++;
				step_bytes.push_back(v);
			end else begin
				dropped = 1'b1;
			end
		endfunction

		// reads at or past the write count give zero
		function logic [7:0] fetch(int unsigned addr);
			if (addr < wr_count && addr < HIST_DEPTH)
				return hist[addr];
			return 8'h00;
		endfunction

		function void finish_cmd();
			remaining = 0;
			phase     = PH_HEADER;
			if (wr_count >= HIST_DEPTH)
				done = 1'b1;
		endfunction

		function void enter_data();
			if (mode == MODE_LITERAL)
				phase = PH_LITERAL;
			else if (mode == MODE_BYTE || mode == MODE_INC)
				phase = PH_SINGLE;
			else
				phase = PH_PAIR_FIRST;
		endfunction

		// one accepted compressed byte: advance the parser and queue its chunks
		function void take_byte(in_item_t it);
			logic [7:0]  b;
			int unsigned start_len, n, nres, base, cnt, k, i, src;
			bit          was_done;
			out_item_t   r;
			b = it.in_byte;
			n_bytes_in++;
			if (it.stream_start)
				clear_stream();
			if (done)
				return;
			was_done  = done;
			start_len = wr_count;
			step_bytes.delete();
			dropped = 1'b0;
			case (phase)
				PH_HEADER: begin
					if (b == END_CODE) begin
						done = 1'b1;
					end else if (b[7:5] == EXT_MARK) begin
						mode      = b[4:2];
						remaining = {b[1:0], 8'h00};
						phase     = PH_EXTCOUNT;
					end else begin
						mode      = b[7:5];
						remaining = b[4:0] + 1;
						enter_data();
					end
				end
				PH_EXTCOUNT: begin
					remaining = {remaining[9:8], b} + 1;
					enter_data();
				end
				PH_LITERAL: begin
					put(b);
					if (remaining > 0)
						remaining--;
					if (remaining == 0)
						finish_cmd();
				end
				PH_SINGLE: begin
					for (i = 0; i < remaining; i++)
						put((mode == MODE_INC) ? 8'(b + i) : b);
					finish_cmd();
				end
				PH_PAIR_FIRST: begin
					held  = b;
					phase = PH_PAIR_SECOND;
				end
				default: begin
					if (mode == MODE_WORD) begin
						for (i = 0; i < remaining; i++)
							put(i[0] ? b : held);
					end else begin
						src = big_endian ? {held, b} : {b, held};
						for (i = 0; i < remaining; i++)
							put(fetch(src + i));
					end
					finish_cmd();
				end
			endcase

			// split into chunks; an empty step still reports an end or a drop
			n    = step_bytes.size();
			nres = (n + CHUNK_BYTES - 1) / CHUNK_BYTES;
			if (nres == 0 && (dropped || (done && !was_done)))
				nres = 1;
			for (k = 0; k < nres; k++) begin
				r    = '0;
				base = k * CHUNK_BYTES;
				cnt  = (n > base) ? n - base : 0;
				if (cnt > CHUNK_BYTES)
					cnt = CHUNK_BYTES;
				for (i = 0; i < cnt; i++) begin
					if (i < 8)
						r.chunk_low[8*i +: 8] = step_bytes[base + i];
					else
						r.chunk_high[8*(i-8) +: 8] = step_bytes[base + i];
				end
				r.byte_count     = 5'(cnt);
				r.last_chunk     = (k + 1 == nres);
				r.stream_done    = done;
				r.overflow       = dropped;
				r.decoded_length = DEC_W'(start_len + base + cnt);
				chunks_due.push_back(r);
			end
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// one accepted output transaction against the oldest owed chunk
		function void check_chunk(out_item_t got);
			out_item_t want;
			n_chunks++;
			if (chunks_due.size() == 0) begin
				$error("chunk with nothing owed: byte_count %0d decoded_length %0d",
					got.byte_count, got.decoded_length);
				errors++;
				return;
			end
			want = chunks_due.pop_front();
			check_field("chunk_low", want.chunk_low, got.chunk_low);
			check_field("chunk_high", want.chunk_high, got.chunk_high);
			check_field("byte_count", want.byte_count, got.byte_count);
			check_field("last_chunk", want.last_chunk, got.last_chunk);
			check_field("stream_done", want.stream_done, got.stream_done);
			check_field("overflow", want.overflow, got.overflow);
			check_field("decoded_length", want.decoded_length, got.decoded_length);
		endfunction
	endclass

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_stall;
	in_item_t  in_data     = '0;
	logic      out_valid;
	logic      out_stall   = 1'b0;
	out_item_t out_data;

	chunk_scoreboard sb;
	in_item_t        stim_q [$];
	bit              start_next;
	bit              tx_quiet;
	bit              rx_quiet;
	int              hold_req;
	int unsigned     n_streams;
	int unsigned     n_fill;

	rle_lz_graphics_decompressor_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always #10 clk = ~clk;

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_byte(in_data);
			if (out_valid && !out_stall)
				sb.check_chunk(out_data);
		end
	end

	// output side: random hold-off per transaction, plus one long hold on request
	initial begin
		int wait_cycles;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				out_stall <= 1'b1;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end
			wait_cycles = rx_quiet ? 0 : $urandom_range(0, 9);
			repeat (wait_cycles) begin
				out_stall <= 1'b1;
				@(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// hard limit on the run
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("rle_lz_graphics_decompressor_unit verification failed");
		$finish;
	end

	task automatic add_byte(logic [7:0] b);
		in_item_t it;
		it.in_byte      = b;
		it.stream_start = start_next;
		start_next      = 1'b0;
		stim_q.push_back(it);
	endtask

	// well-formed stream of random commands; a fill stream runs into the history limit
	task automatic gen_stream(bit fill, bit big);
		int unsigned made, run, room, ncmd, c, i;
		logic [2:0]  m;
		logic [9:0]  cnt;
		logic [15:0] src;
		bit          ext;
		made       = 0;
		start_next = 1'b1;
		n_streams++;
		if (fill)
			n_fill++;
		ncmd = fill ? 64 : $urandom_range(1, 8);
		for (c = 0; c < ncmd && made < HIST_DEPTH; c++) begin
			room = HIST_DEPTH - made;
			m    = 3'($urandom_range(0, 7));
			if (!fill) begin
				run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_RUN_LEN)
					: $urandom_range(1, 40);
			end else if (room <= 20) begin
				// literal that lands on or crosses the history limit
				m   = MODE_LITERAL;
				run = room + $urandom_range(0, 4);
			end else if (room > 1100) begin
				run = $urandom_range(300, MAX_RUN_LEN);
			end else begin
				run = $urandom_range(0, 1) ? room - $urandom_range(1, 20)
					: room + $urandom_range(0, 30);
			end
			if (run > MAX_RUN_LEN)
				run = MAX_RUN_LEN;
			if (m == MODE_LITERAL && run > 24)
				run = $urandom_range(1, 24);
			// mode 7 with the top count bits set would read as the end code
			if (m == MODE_COPY_TOP && run > 768)
				m = 3'($urandom_range(MODE_COPY_FIRST, MODE_COPY_TOP - 1));
			ext = (run > 32) || (m == MODE_COPY_TOP) || ($urandom_range(0, 5) == 0);
			cnt = 10'(run - 1);
			if (ext) begin
				add_byte({EXT_MARK, m, cnt[9:8]});
				add_byte(cnt[7:0]);
			end else begin
				add_byte({m, cnt[4:0]});
			end
			case (m)
				MODE_LITERAL: begin
					for (i = 0; i < run; i++)
						add_byte(8'($urandom_range(0, 255)));
				end
				MODE_BYTE, MODE_INC: add_byte(8'($urandom_range(0, 255)));
				MODE_WORD: begin
					add_byte(8'($urandom_range(0, 255)));
					add_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					src = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, made));
					add_byte(big ? src[15:8] : src[7:0]);
					add_byte(big ? src[7:0] : src[15:8]);
				end
			endcase
			made = (made + run > HIST_DEPTH) ? HIST_DEPTH : made + run;
		end
		if (made >= HIST_DEPTH) begin
			// stream already over: these bytes are ignored
			repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
		end else if ($urandom_range(0, 5) == 0) begin
			// cut off mid-command by the next stream
			add_byte(8'($urandom_range(0, 254)));
			if ($urandom_range(0, 1))
				add_byte(8'($urandom_range(0, 255)));
		end else begin
			add_byte(END_CODE);
			if ($urandom_range(0, 3) == 0)
				add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// unstructured bytes at the head of a fresh stream
	task automatic gen_noise();
		start_next = 1'b1;
		n_streams++;
		repeat ($urandom_range(4, 12)) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic build_phase(int target, bit big);
		int pick;
		gen_stream(1'b1, big);
		while (stim_q.size() < target) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				gen_noise();
			else
				gen_stream(pick == 1, big);
		end
	endtask

	task automatic wait_drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// offer every queued transaction; optionally stop and let the output drain midway
	task automatic send_all(int pause_at);
		int gap, idx;
		for (idx = 0; idx < stim_q.size(); idx++) begin
			if (idx == pause_at) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait_drain();
			end
			gap = tx_quiet ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			in_data  <= stim_q[idx];
			do @(posedge clk); while (!(in_valid && !in_stall));
		end
		@(negedge clk);
		in_valid <= 1'b0;
		stim_q.delete();
	endtask

	// offset order register, written only with the block idle
	task automatic write_order(bit v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.big_endian = v;
	endtask

	task automatic settle();
		wait_drain();
		repeat (40) @(posedge clk);
	endtask

	initial begin
		logic [7:0] prog [26];
		int         i;
		sb        = new();
		hold_req  = 0;
		tx_quiet  = 1'b0;
		rx_quiet  = 1'b0;
		n_streams = 0;
		n_fill    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: every mode but 6, count extremes, wrap, copy past the write count,
		// extended mode 7 copy, end code and a byte ignored after the end
		prog = '{8'h02, 8'h00, 8'hFF, 8'h80,
			8'h21, 8'hAA,
			8'h43, 8'h12, 8'h34,
			8'h7F, 8'hF0,
			8'h84, 8'h00, 8'h00,
			8'hA0, 8'hFF, 8'hFF,
			8'hE7, 8'hFF, 8'h5A,
			8'hFD, 8'h00, 8'h03, 8'h00,
			8'hFF, 8'h11};
		write_order(1'b0);
		start_next = 1'b1;
		n_streams++;
		for (i = 0; i < 26; i++)
			add_byte(prog[i]);
		send_all(-1);
		settle();

		// random, big-endian offsets, normal idling
		write_order(1'b1);
		build_phase(55, 1'b1);
		send_all(-1);
		settle();

		// long output hold while the input side keeps pushing
		write_order(1'b0);
		build_phase(55, 1'b0);
		tx_quiet = 1'b1;
		hold_req = 600;
		send_all(-1);
		settle();

		// no idling on either side
		write_order(1'b1);
		build_phase(55, 1'b1);
		rx_quiet = 1'b1;
		send_all(-1);
		settle();

		// normal idling with a full drain halfway through
		write_order(1'b0);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		build_phase(55, 1'b0);
		send_all(stim_q.size() / 2);
		wait_drain();
		repeat (50) @(posedge clk);

		$display("checked %0d chunks from %0d compressed bytes over %0d streams",
			sb.n_chunks, sb.n_bytes_in, n_streams);
		$display("%0d streams ran into the history limit; both offset orders used",
			n_fill);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("rle_lz_graphics_decompressor_unit verification clean");
		end else begin
			$display("rle_lz_graphics_decompressor_unit verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/rlzgd_pkg.sv
rtl/rlzgd_ram.sv
rtl/rle_lz_graphics_decompressor_unit.sv
rtl/rlzgd_checker.sv
dv/tb.sv
